@@ rtl/gdpt_pkg.sv @@
// Package for the gcd divides-product test: shared constants.
package gdpt_pkg;

	// Default width of the divisor, factor and residual values.
	localparam int unsigned VALUE_BITS_DEF = 31;

endpackage

@@ rtl/gcd_divides_product_test_top.sv @@
// Top level of the gcd divides-product test: sequencer, shared subtractor and result register.
//
// This block decides whether a divisor divides the product of a stream of factors
// without ever forming that product. A transfer with kind = 0 loads its value as the
// residual and starts a new case. Each transfer with kind = 1 is a factor f, and the
// residual r becomes r / gcd(r, f). A transfer with last = 1 yields one result transfer
// once it has been applied: divides is 1 when the residual has reached 1, and residual
// carries the value left over. Items after a last item without a new divisor keep
// reducing the held residual. A factor of zero drives a nonzero residual to 1. A divisor
// load goes straight to the finishing state. A factor first runs a binary gcd on one
// shared subtractor; the number of gcd steps depends on the operand values. Unless the
// gcd is zero, an exact restoring division of the residual by the gcd then runs on the
// same subtractor, followed by the finishing state. The gcd steps and the division
// steps share the subtractor and the step counter. in_ready is high only while the
// sequencer is idle. A finished result sits in an output register; the next input
// transfer is taken while it waits, and the sequencer only stalls when a second result
// is ready before the first has been taken.
module gcd_divides_product_test_top
	import gdpt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  divides,
	output logic [VALUE_BITS-1:0] residual
);

	localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] remaining_q;
	logic [VALUE_BITS-1:0] a_q;
	logic [VALUE_BITS-1:0] b_q;
	logic [VALUE_BITS-1:0] g_q;
	logic [VALUE_BITS-1:0] num_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  divides_q;
	logic [VALUE_BITS-1:0] residual_q;

	// The one subtractor, shared by the gcd steps and the division steps.
	logic [VALUE_BITS:0] sub_a;
	logic [VALUE_BITS:0] sub_b;
	logic [VALUE_BITS:0] diff;
	logic                no_borrow;

	// Gcd result once one operand has reached zero.
	logic                  gcd_end;
	logic [VALUE_BITS-1:0] gcd_val;

	// A finished last item moves its result into the output register this cycle.
	logic                  post_result;

	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = {rem_q, num_q[VALUE_BITS-1]};
			sub_b = {1'b0, g_q};
		end else begin
			sub_a = {1'b0, a_q};
			sub_b = {1'b0, b_q};
		end
		diff      = sub_a - sub_b;
		no_borrow = ~diff[VALUE_BITS];
	end

	assign gcd_end = (a_q == '0) || (b_q == '0);
	assign gcd_val = ((a_q == '0) ? b_q : a_q) << cnt_q;

	assign post_result = (state_q == ST_DONE) && last_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			remaining_q <= VALUE_BITS'(1);
			a_q         <= '0;
			b_q         <= '0;
			g_q         <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			divides_q   <= 1'b0;
			residual_q  <= '0;
		end else begin
			if (post_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= last;
						cnt_q  <= '0;
						if (!kind) begin
							remaining_q <= value;
							state_q     <= ST_DONE;
						end else begin
							a_q     <= remaining_q;
							b_q     <= value;
							state_q <= ST_GCD;
						end
					end
				end
				ST_GCD: begin
					if (gcd_end) begin
						// A zero gcd only arises when both operands are zero:
						// the residual is then left unchanged.
						g_q   <= gcd_val;
						num_q <= remaining_q;
						rem_q <= '0;
						cnt_q <= '0;
						if (gcd_val == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end else if (!a_q[0] && !b_q[0]) begin
						a_q   <= a_q >> 1;
						b_q   <= b_q >> 1;
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (no_borrow) begin
						a_q <= diff[VALUE_BITS:1];
					end else begin
						a_q <= b_q;
						b_q <= a_q;
					end
				end
				ST_DIV: begin
					if (no_borrow) begin
						rem_q <= diff[VALUE_BITS-1:0];
					end else begin
						rem_q <= sub_a[VALUE_BITS-1:0];
					end
					num_q <= {num_q[VALUE_BITS-2:0], no_borrow};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						remaining_q <= {num_q[VALUE_BITS-2:0], no_borrow};
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (post_result) begin
						divides_q  <= (remaining_q == VALUE_BITS'(1));
						residual_q <= remaining_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign divides   = divides_q;
	assign residual  = residual_q;

endmodule

@@ rtl/gdpt_checker.sv @@
// Port-level checker for the gcd divides-product test, with its bind statement.
module gdpt_checker
	import gdpt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  kind,
	input logic [VALUE_BITS-1:0] value,
	input logic                  last,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  divides,
	input logic [VALUE_BITS-1:0] residual
);

	// A stalled result keeps its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(divides) && $stable(residual))
		else $error("result changed while stalled");

	// The flag must agree with the residual it comes with.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (divides == (residual == VALUE_BITS'(1))))
		else $error("divides flag disagrees with residual");

	// Every accepted item moves the sequencer out of idle, so input is blocked right after a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// A new result is posted as the sequencer returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while sequencer busy");

	// An offered input transfer keeps its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(value) && $stable(last))
		else $error("input payload changed while waiting");

endmodule

bind gcd_divides_product_test_top gdpt_checker #(.VALUE_BITS(VALUE_BITS)) u_gdpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.kind     (kind),
	.value    (value),
	.last     (last),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.divides  (divides),
	.residual (residual)
);

@@ dv/gcd_divides_product_test_top_test.sv @@
// Self-checking testbench for the gcd divides-product test block.
`timescale 1ns / 1ps

module gcd_divides_product_test_top_test;
	import gdpt_pkg::*;

	localparam int unsigned VB = VALUE_BITS_DEF;
	localparam int unsigned ITEM_TARGET = 1350;
	// The settling time allows for the slowest factor inside the block.
	localparam int unsigned SETTLE_CYCLES = 4 * VB + 40;
	localparam int unsigned HOLD_CYCLES = 700;
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam logic [63:0] VALUE_MAX = (64'd1 << VB) - 1;

	typedef enum logic {
		KIND_DIVISOR = 1'b0,
		KIND_FACTOR  = 1'b1
	} item_kind_e;

	// One result transfer: the divisibility verdict and the residual left over.
	typedef struct packed {
		logic          divides;
		logic [VB-1:0] residual;
	} verdict_t;

	// One row of the directed table. Rows with typed set carry an expectation read
	// straight off the behavior; the rest are checked against the predictor.
	typedef struct packed {
		item_kind_e    kind;
		logic [VB-1:0] value;
		logic          last;
		logic          typed;
		verdict_t      verdict;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          kind;
	logic [VB-1:0] value;
	logic          last;
	logic          out_valid;
	logic          out_ready;
	logic          divides;
	logic [VB-1:0] residual;

	gcd_divides_product_test_top #(
		.VALUE_BITS(VB)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.value    (value),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.divides  (divides),
		.residual (residual)
	);

	// The predictor keeps its own copy of the residual that the block holds.
	logic [VB-1:0] held_residual;
	verdict_t      pending_results[$];
	stim_row_t     directed_rows[$];

	int unsigned items_sent;
	int unsigned divisor_loads;
	int unsigned factors_sent;
	int unsigned results_taken;
	int unsigned results_dividing;
	int unsigned mismatches;
	int unsigned cycles;
	bit          hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Plain Euclid on the predictor's side; gcd(r, 0) is r and gcd(0, 0) is 0.
	function automatic logic [VB-1:0] common_divisor(logic [VB-1:0] a, logic [VB-1:0] b);
		logic [VB-1:0] t;
		while (b != '0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Applies one accepted transfer to the held residual and returns the verdict
	// that a last transfer would report.
	function automatic verdict_t reduce_residual(item_kind_e k, logic [VB-1:0] v);
		logic [VB-1:0] g;
		verdict_t      res;
		if (k == KIND_DIVISOR) begin
			held_residual = v;
		end else begin
			g = common_divisor(held_residual, v);
			// A zero gcd only happens for a zero residual and a zero factor.
			if (g != '0)
				held_residual = held_residual / g;
		end
		res.divides = (held_residual == VB'(1));
		res.residual = held_residual;
		return res;
	endfunction

	function automatic int unsigned prime_at(int unsigned idx);
		case (idx)
			0: return 2;
			1: return 3;
			2: return 5;
			3: return 7;
			4: return 11;
			5: return 13;
			6: return 127;
			default: return 8191;
		endcase
	endfunction

	// Half the values are smooth numbers built from a few primes, so that factors and
	// divisors share enough to make both verdicts common. The rest are full-width
	// random values, small values, powers of two and the extremes, zero included.
	function automatic logic [VB-1:0] pick_value();
		logic [63:0]  acc;
		int unsigned  p;
		int unsigned  n;
		acc = 64'd1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					p = prime_at($urandom_range(0, 7));
					if (acc * p <= VALUE_MAX)
						acc = acc * p;
				end
			end
			5, 6: acc = 64'($urandom()) & VALUE_MAX;
			7: acc = 64'($urandom_range(1, 255));
			8: begin
				case ($urandom_range(0, 4))
					0: acc = 64'd0;
					1: acc = 64'd1;
					2: acc = VALUE_MAX;
					3: acc = VALUE_MAX - 1;
					default: acc = 64'd1 << (VB - 1);
				endcase
			end
			default: acc = 64'd1 << $urandom_range(0, VB - 1);
		endcase
		return acc[VB-1:0];
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	function automatic void add_row(item_kind_e k, logic [VB-1:0] v, logic l, logic typed,
			logic exp_div, logic [VB-1:0] exp_res);
		stim_row_t row;
		row.kind = k;
		row.value = v;
		row.last = l;
		row.typed = typed;
		row.verdict.divides = exp_div;
		row.verdict.residual = exp_res;
		directed_rows.push_back(row);
	endfunction

	// Offers one transfer on the input side, starting and ending at a falling edge.
	// Once it is accepted the predictor is updated, and a last transfer queues its
	// verdict: the typed one where the row carries it, else the predicted one.
	task automatic send_item(input item_kind_e k, input logic [VB-1:0] v, input logic l,
			input logic typed, input verdict_t typed_verdict);
		int unsigned gap;
		verdict_t    predicted;
		// Every fourth stretch of 150 transfers runs with no sender gaps at all.
		gap = (((items_sent / 150) % 4) == 2) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		last <= l;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (k == KIND_DIVISOR)
			divisor_loads++;
		else
			factors_sent++;
		predicted = reduce_residual(k, v);
		if (l)
			pending_results.push_back(typed ? typed_verdict : predicted);
		@(negedge clk);
	endtask

	// One case: a divisor, up to five factors, the final transfer marked last.
	// With no factors the divisor itself carries last.
	task automatic run_case();
		int unsigned nf;
		nf = $urandom_range(0, 5);
		send_item(KIND_DIVISOR, pick_value(), nf == 0, 1'b0, '0);
		for (int unsigned i = 0; i < nf; i++)
			send_item(KIND_FACTOR, pick_value(), i == nf - 1, 1'b0, '0);
	endtask

	// Receiver: random stalls with quiet stretches, and once, after a few dozen
	// results, a long hold-off while the sender keeps offering transfers. The
	// block holds one finished result, so it has to stop taking input.
	initial begin
		int unsigned stall_left;
		out_ready = 1'b0;
		stall_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_taken >= 30) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (((cycles / 2000) % 4) != 1 && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Each result transfer is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			results_taken++;
			if (divides)
				results_dividing++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending, residual", '0, 64'(residual));
			end else begin
				want = pending_results.pop_front();
				if (divides !== want.divides)
					flag_mismatch("divides", 64'(want.divides), 64'(divides));
				if (residual !== want.residual)
					flag_mismatch("residual", 64'(want.residual), 64'(residual));
			end
		end
	end

	// Watchdog: a run that is far slower than the worst correct case has hung.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending", cycles,
				pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_DIVISOR;
		value = '0;
		last = 1'b0;
		held_residual = VB'(1);
		items_sent = 0;
		divisor_loads = 0;
		factors_sent = 0;
		results_taken = 0;
		results_dividing = 0;
		mismatches = 0;
		cycles = 0;

		// Directed cases. A factor ahead of any divisor meets the reset residual of one.
		add_row(KIND_FACTOR, 12, 1'b1, 1'b1, 1'b1, 1);
		// A divisor that carries last is reported unreduced.
		add_row(KIND_DIVISOR, 1, 1'b1, 1'b1, 1'b1, 1);
		add_row(KIND_DIVISOR, VALUE_MAX[VB-1:0], 1'b1, 1'b1, 1'b0, VALUE_MAX[VB-1:0]);
		add_row(KIND_DIVISOR, 0, 1'b1, 1'b1, 1'b0, 0);
		// A zero divisor stays zero, whatever the factor, a zero factor included.
		add_row(KIND_DIVISOR, 0, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 5, 1'b1, 1'b1, 1'b0, 0);
		add_row(KIND_DIVISOR, 0, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 0, 1'b1, 1'b1, 1'b0, 0);
		// A zero factor makes the product zero, so any divisor divides it.
		add_row(KIND_DIVISOR, 12, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 0, 1'b1, 1'b1, 1'b1, 1);
		add_row(KIND_DIVISOR, 12, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 8, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 9, 1'b1, 1'b0, 1'b0, 0);
		// The largest value is prime, and it divides itself.
		add_row(KIND_DIVISOR, VALUE_MAX[VB-1:0], 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, VALUE_MAX[VB-1:0], 1'b1, 1'b1, 1'b1, 1);
		add_row(KIND_DIVISOR, VB'(64'd1 << (VB - 1)), 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 2, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, VB'(64'd1 << (VB - 1)), 1'b1, 1'b0, 1'b0, 0);
		// After a last transfer, further factors keep reducing the held residual.
		add_row(KIND_DIVISOR, 97, 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 3, 1'b1, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, 97, 1'b1, 1'b0, 1'b0, 0);
		// Consecutive values are coprime; this is also the longest gcd.
		add_row(KIND_DIVISOR, VB'(VALUE_MAX - 1), 1'b0, 1'b0, 1'b0, 0);
		add_row(KIND_FACTOR, VALUE_MAX[VB-1:0], 1'b1, 1'b1, 1'b0, VB'(VALUE_MAX - 1));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].verdict);

		// Random part: mostly well-formed cases, about one in ten a stray transfer
		// with random kind and last, which also exercises factors after a last.
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				send_item(item_kind_e'($urandom_range(0, 1)), VB'($urandom()),
					1'($urandom_range(0, 1)), 1'b0, '0);
			else
				run_case();
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// Let the block run out, so that any stray extra result is still caught.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d transfers: %0d divisor loads and %0d factors.", items_sent,
			divisor_loads, factors_sent);
		$display("Checked %0d results, %0d of them dividing; %0d mismatches.", results_taken,
			results_dividing, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
